@@ rtl/bslm_pkg.sv @@
// Package with the shared types, codes and reset values of the battery safety limit manager.
package bslm_pkg;

  localparam int unsigned PCT_W    = 7;
  localparam int unsigned REQ_W    = 8;
  localparam int unsigned RUN_W    = 4;
  localparam int unsigned REASON_W = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  // Register reset values.
  localparam logic [PCT_W-1:0] BASE_LIMIT_RST   = 7'd80;
  localparam logic [PCT_W-1:0] ONE_WARN_RST     = 7'd60;
  localparam logic [PCT_W-1:0] TWO_WARN_RST     = 7'd40;
  localparam logic [PCT_W-1:0] THREE_WARN_RST   = 7'd0;
  localparam logic [PCT_W-1:0] RAMP_DOWN_RST    = 7'd2;
  localparam logic [PCT_W-1:0] RAMP_DANGER_RST  = 7'd3;
  localparam logic [PCT_W-1:0] RAMP_UP_RST      = 7'd3;
  localparam logic [RUN_W-1:0] DEBOUNCE_RST     = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_LIMIT  = 3'd0,
    REG_ONE_WARN    = 3'd1,
    REG_TWO_WARN    = 3'd2,
    REG_THREE_WARN  = 3'd3,
    REG_RAMP_DOWN   = 3'd4,
    REG_RAMP_DANGER = 3'd5,
    REG_RAMP_UP     = 3'd6,
    REG_DEBOUNCE    = 3'd7
  } cfg_idx_t;

  // Temperature and gas sensor grades.
  localparam logic [1:0] SENS_NORMAL = 2'd0;
  localparam logic [1:0] SENS_WARN   = 2'd1;
  localparam logic [1:0] SENS_DANGER = 2'd2;
  localparam logic [1:0] SENS_FAULT  = 2'd3;

  localparam logic [2:0] VOLT_OVER_WARN  = 3'd1;
  localparam logic [2:0] VOLT_UNDER_WARN = 3'd2;
  localparam logic [2:0] VOLT_HI_DANGER  = 3'd3;
  localparam logic [2:0] VOLT_LO_DANGER  = 3'd4;

  localparam logic [1:0] CURR_WARN   = 2'd1;
  localparam logic [1:0] CURR_DANGER = 2'd2;

  typedef enum logic [REASON_W-1:0] {
    RSN_SAFE         = 4'd0,
    RSN_TEMP_FAULT   = 4'd1,
    RSN_TEMP_DANGER  = 4'd2,
    RSN_GAS_FAULT    = 4'd3,
    RSN_GAS_DANGER   = 4'd4,
    RSN_ELEC_INVALID = 4'd5,
    RSN_VOLT_OVER_D  = 4'd6,
    RSN_VOLT_UNDER_D = 4'd7,
    RSN_CURR_DANGER  = 4'd8,
    RSN_TEMP_WARN    = 4'd9,
    RSN_GAS_WARN     = 4'd10,
    RSN_VOLT_OVER_W  = 4'd11,
    RSN_VOLT_UNDER_W = 4'd12,
    RSN_CURR_WARN    = 4'd13
  } reason_t;

  typedef struct packed {
    logic [PCT_W-1:0] base_limit;
    logic [PCT_W-1:0] one_warn;
    logic [PCT_W-1:0] two_warn;
    logic [PCT_W-1:0] three_warn;
    logic [PCT_W-1:0] ramp_down;
    logic [PCT_W-1:0] ramp_danger;
    logic [PCT_W-1:0] ramp_up;
    logic [RUN_W-1:0] debounce;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       temp_grade;
    logic [1:0]       gas_state;
    logic [2:0]       volt_state;
    logic [1:0]       curr_state;
    logic             elec_ok;
    logic             clear_latch;
    logic [REQ_W-1:0] request_pct;
  } item_t;

  typedef struct packed {
    logic [REQ_W-1:0]    limited_pct;
    logic [PCT_W-1:0]    applied_pct;
    logic [PCT_W-1:0]    target_pct;
    logic [1:0]          warn_count;
    logic                danger_now;
    logic                danger_latched;
    logic                elec_warn;
    logic                elec_danger;
    logic [REASON_W-1:0] now_reason;
    logic [REASON_W-1:0] latched_reason;
    logic [REASON_W-1:0] banner_reason;
  } result_t;

endpackage

@@ rtl/bslm_in_if.sv @@
// Input channel interface carrying one evaluation period per transfer.
interface bslm_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               temp_grade;
  logic [1:0]               gas_state;
  logic [2:0]               volt_state;
  logic [1:0]               curr_state;
  logic                     elec_ok;
  logic                     clear_latch;
  logic [bslm_pkg::REQ_W-1:0] request_pct;

  modport source (output valid, temp_grade, gas_state, volt_state, curr_state,
                  elec_ok, clear_latch, request_pct, input ready);
  modport sink (input valid, temp_grade, gas_state, volt_state, curr_state,
                elec_ok, clear_latch, request_pct, output ready);
endinterface

@@ rtl/bslm_out_if.sv @@
// Result channel interface carrying the limit decision of one period.
interface bslm_out_if;
  logic                          valid;
  logic                          ready;
  logic [bslm_pkg::REQ_W-1:0]    limited_pct;
  logic [bslm_pkg::PCT_W-1:0]    applied_pct;
  logic [bslm_pkg::PCT_W-1:0]    target_pct;
  logic [1:0]                    warn_count;
  logic                          danger_now;
  logic                          danger_latched;
  logic                          elec_warn;
  logic                          elec_danger;
  logic [bslm_pkg::REASON_W-1:0] now_reason;
  logic [bslm_pkg::REASON_W-1:0] latched_reason;
  logic [bslm_pkg::REASON_W-1:0] banner_reason;

  modport source (output valid, limited_pct, applied_pct, target_pct, warn_count,
                  danger_now, danger_latched, elec_warn, elec_danger, now_reason,
                  latched_reason, banner_reason, input ready);
  modport sink (input valid, limited_pct, applied_pct, target_pct, warn_count,
                danger_now, danger_latched, elec_warn, elec_danger, now_reason,
                latched_reason, banner_reason, output ready);
endinterface

@@ rtl/bslm_cfg_regs.sv @@
// Configuration register file with write-only access.
module bslm_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bslm_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bslm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output bslm_pkg::cfg_t                      cfg
);

  bslm_pkg::cfg_t cfg_r;
  bslm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (bslm_pkg::cfg_idx_t'(cfg_idx))
        bslm_pkg::REG_BASE_LIMIT:  cfg_nxt.base_limit  = cfg_wdata;
        bslm_pkg::REG_ONE_WARN:    cfg_nxt.one_warn    = cfg_wdata;
        bslm_pkg::REG_TWO_WARN:    cfg_nxt.two_warn    = cfg_wdata;
        bslm_pkg::REG_THREE_WARN:  cfg_nxt.three_warn  = cfg_wdata;
        bslm_pkg::REG_RAMP_DOWN:   cfg_nxt.ramp_down   = cfg_wdata;
        bslm_pkg::REG_RAMP_DANGER: cfg_nxt.ramp_danger = cfg_wdata;
        bslm_pkg::REG_RAMP_UP:     cfg_nxt.ramp_up     = cfg_wdata;
        bslm_pkg::REG_DEBOUNCE:    cfg_nxt.debounce    = cfg_wdata[bslm_pkg::RUN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_limit  <= bslm_pkg::BASE_LIMIT_RST;
      cfg_r.one_warn    <= bslm_pkg::ONE_WARN_RST;
      cfg_r.two_warn    <= bslm_pkg::TWO_WARN_RST;
      cfg_r.three_warn  <= bslm_pkg::THREE_WARN_RST;
      cfg_r.ramp_down   <= bslm_pkg::RAMP_DOWN_RST;
      cfg_r.ramp_danger <= bslm_pkg::RAMP_DANGER_RST;
      cfg_r.ramp_up     <= bslm_pkg::RAMP_UP_RST;
      cfg_r.debounce    <= bslm_pkg::DEBOUNCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/bslm_eval.sv @@
// Single-pass evaluation of one period: grading, debounce, latch and limit ramp.
module bslm_eval (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  bslm_pkg::item_t   item,
  input  bslm_pkg::cfg_t    cfg,
  output bslm_pkg::result_t res
);

  logic [bslm_pkg::RUN_W-1:0]    danger_run_r, danger_run_nxt;
  logic                          latch_flag_r, latch_flag_nxt;
  logic [bslm_pkg::REASON_W-1:0] latch_code_r, latch_code_nxt;
  logic [bslm_pkg::PCT_W-1:0]    applied_r, applied_nxt;

  logic                          ed, ew, t_dng, g_dng, raw, dnow;
  logic [1:0]                    warns;
  bslm_pkg::reason_t             reason;
  logic [bslm_pkg::PCT_W-1:0]    target, step, diff;
  logic [bslm_pkg::REASON_W-1:0] banner;

  // Electrical grading; an undefined voltage or current code counts as normal.
  always_comb begin
    ed = !item.elec_ok || (item.volt_state == bslm_pkg::VOLT_HI_DANGER) ||
         (item.volt_state == bslm_pkg::VOLT_LO_DANGER) ||
         (item.curr_state == bslm_pkg::CURR_DANGER);
    ew = !ed && ((item.volt_state == bslm_pkg::VOLT_OVER_WARN) ||
                 (item.volt_state == bslm_pkg::VOLT_UNDER_WARN) ||
                 (item.curr_state == bslm_pkg::CURR_WARN));
  end

  always_comb begin
    priority if (item.temp_grade == bslm_pkg::SENS_FAULT) reason = bslm_pkg::RSN_TEMP_FAULT;
    else if (item.temp_grade == bslm_pkg::SENS_DANGER) reason = bslm_pkg::RSN_TEMP_DANGER;
    else if (item.gas_state == bslm_pkg::SENS_FAULT) reason = bslm_pkg::RSN_GAS_FAULT;
    else if (item.gas_state == bslm_pkg::SENS_DANGER) reason = bslm_pkg::RSN_GAS_DANGER;
    else if (!item.elec_ok) reason = bslm_pkg::RSN_ELEC_INVALID;
    else if (item.volt_state == bslm_pkg::VOLT_HI_DANGER) reason = bslm_pkg::RSN_VOLT_OVER_D;
    else if (item.volt_state == bslm_pkg::VOLT_LO_DANGER) reason = bslm_pkg::RSN_VOLT_UNDER_D;
    else if (item.curr_state == bslm_pkg::CURR_DANGER) reason = bslm_pkg::RSN_CURR_DANGER;
    else if (item.temp_grade == bslm_pkg::SENS_WARN) reason = bslm_pkg::RSN_TEMP_WARN;
    else if (item.gas_state == bslm_pkg::SENS_WARN) reason = bslm_pkg::RSN_GAS_WARN;
    else if (item.volt_state == bslm_pkg::VOLT_OVER_WARN) reason = bslm_pkg::RSN_VOLT_OVER_W;
    else if (item.volt_state == bslm_pkg::VOLT_UNDER_WARN) reason = bslm_pkg::RSN_VOLT_UNDER_W;
    else if (item.curr_state == bslm_pkg::CURR_WARN) reason = bslm_pkg::RSN_CURR_WARN;
    else reason = bslm_pkg::RSN_SAFE;
  end

  always_comb begin
    t_dng = (item.temp_grade == bslm_pkg::SENS_DANGER) ||
            (item.temp_grade == bslm_pkg::SENS_FAULT);
    g_dng = (item.gas_state == bslm_pkg::SENS_DANGER) ||
            (item.gas_state == bslm_pkg::SENS_FAULT);
    raw   = t_dng || g_dng || ed;

    warns = {1'b0, item.temp_grade == bslm_pkg::SENS_WARN} +
            {1'b0, item.gas_state == bslm_pkg::SENS_WARN} + {1'b0, ew};

    // The run counter saturates at the debounce setting and the test uses the
    // updated count, so a setting of zero makes gas danger immediate.
    if (!raw) begin
      danger_run_nxt = '0;
    end else if (danger_run_r < cfg.debounce) begin
      danger_run_nxt = danger_run_r + 1'b1;
    end else begin
      danger_run_nxt = danger_run_r;
    end
    dnow = raw && (t_dng || ed || (danger_run_nxt >= cfg.debounce));

    // Pending gas danger counts as at least one warning.
    if (raw && !dnow && (warns == 2'd0)) begin
      warns = 2'd1;
    end
  end

  // A clear acts before this period's latch decision.
  always_comb begin
    latch_flag_nxt = item.clear_latch ? 1'b0 : latch_flag_r;
    latch_code_nxt = item.clear_latch ? '0 : latch_code_r;
    if (dnow && !latch_flag_nxt) begin
      latch_flag_nxt = 1'b1;
      latch_code_nxt = reason;
    end
  end

  always_comb begin
    if (dnow) begin
      target = '0;
    end else begin
      unique case (warns)
        2'd0: target = cfg.base_limit;
        2'd1: target = cfg.one_warn;
        2'd2: target = cfg.two_warn;
        2'd3: target = cfg.three_warn;
      endcase
    end

    step        = cfg.ramp_up;
    diff        = '0;
    applied_nxt = applied_r;
    if (applied_r > target) begin
      step = dnow ? cfg.ramp_danger : cfg.ramp_down;
      diff = applied_r - target;
      applied_nxt = (diff > step) ? (applied_r - step) : target;
    end else if (applied_r < target) begin
      diff = target - applied_r;
      applied_nxt = (diff > step) ? (applied_r + step) : target;
    end

    priority if (dnow || (warns != 2'd0)) banner = reason;
    else if (latch_flag_nxt) banner = latch_code_nxt;
    else banner = bslm_pkg::RSN_SAFE;
  end

  always_comb begin
    res.limited_pct    = (item.request_pct > {1'b0, applied_nxt}) ?
                         {1'b0, applied_nxt} : item.request_pct;
    res.applied_pct    = applied_nxt;
    res.target_pct     = target;
    res.warn_count     = warns;
    res.danger_now     = dnow;
    res.danger_latched = latch_flag_nxt;
    res.elec_warn      = ew;
    res.elec_danger    = ed;
    res.now_reason     = reason;
    res.latched_reason = latch_code_nxt;
    res.banner_reason  = banner;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      danger_run_r <= '0;
      latch_flag_r <= 1'b0;
      latch_code_r <= '0;
      applied_r    <= bslm_pkg::BASE_LIMIT_RST;
    end else if (adv) begin
      danger_run_r <= danger_run_nxt;
      latch_flag_r <= latch_flag_nxt;
      latch_code_r <= latch_code_nxt;
      applied_r    <= applied_nxt;
    end
  end

endmodule

@@ rtl/battery_safety_limit_manager.sv @@
// An input transfer is captured in the item register; its result is registered in the output
// register once that is free. Throughput: one period per cycle unless output ready stalls.
// The input register takes one more period while a result waits, then input ready follows
// output ready combinationally.
// Synchronous active-low reset empties both registers, clears the debounce run and
// the danger latch, sets the applied limit to 80 and loads the register defaults.
module battery_safety_limit_manager (
  input  logic                            clk,
  input  logic                            rst_n,
  bslm_in_if.sink                         in_ch,
  bslm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bslm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bslm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bslm_pkg::cfg_t    cfg;
  bslm_pkg::item_t   s1_item_r;
  logic              s1_vld_r, s1_vld_nxt;
  bslm_pkg::result_t res, out_r;
  logic              out_vld_r, out_vld_nxt;
  logic              adv, in_xfer;

  bslm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bslm_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // The held item moves into the result register whenever that register is free.
  assign adv         = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_vld_nxt  = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_vld_r);
    out_vld_nxt = adv ? 1'b1 : ((out_vld_r && out_ch.ready) ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.temp_grade  <= in_ch.temp_grade;
      s1_item_r.gas_state   <= in_ch.gas_state;
      s1_item_r.volt_state  <= in_ch.volt_state;
      s1_item_r.curr_state  <= in_ch.curr_state;
      s1_item_r.elec_ok     <= in_ch.elec_ok;
      s1_item_r.clear_latch <= in_ch.clear_latch;
      s1_item_r.request_pct <= in_ch.request_pct;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.limited_pct    = out_r.limited_pct;
  assign out_ch.applied_pct    = out_r.applied_pct;
  assign out_ch.target_pct     = out_r.target_pct;
  assign out_ch.warn_count     = out_r.warn_count;
  assign out_ch.danger_now     = out_r.danger_now;
  assign out_ch.danger_latched = out_r.danger_latched;
  assign out_ch.elec_warn      = out_r.elec_warn;
  assign out_ch.elec_danger    = out_r.elec_danger;
  assign out_ch.now_reason     = out_r.now_reason;
  assign out_ch.latched_reason = out_r.latched_reason;
  assign out_ch.banner_reason  = out_r.banner_reason;

`ifndef SYNTHESIS
  // Danger forces a zero target and is always captured by the latch with a cause.
  a_danger_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.danger_now) |->
      (out_r.target_pct == '0 && out_r.danger_latched &&
       out_r.latched_reason != bslm_pkg::RSN_SAFE))
    else $error("danger result without zero target or latched reason");

  // The electrical group is never graded warning and danger at once.
  a_elec_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_r.elec_warn && out_r.elec_danger))
    else $error("electrical warning and danger both set");

  // A result that moves into a full, stalled output register would be lost.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |-> !adv)
    else $error("pending result overwritten");
`endif

endmodule

@@ verif/bslm_limit_check.sv @@
// Monitor that predicts each period's limit decision and compares it with the block's results.
`timescale 1ns / 100ps

module bslm_limit_check
  import bslm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  bslm_in_if                   in_ch,
  bslm_out_if                  out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                   mismatches,
  output int                   pending
);

  cfg_t             limits;
  logic [RUN_W-1:0] gas_run;
  logic             latched;
  reason_t          latched_code;
  logic [PCT_W-1:0] applied;

  result_t expected_limits[$];
  result_t exp_r;
  item_t   seen;

  function automatic result_t predict_period(item_t it);
    result_t          r;
    logic             ew;
    logic             ed;
    logic             tdng;
    logic             gdng;
    logic             dnow;
    int               warns;
    int               step;
    int               gap;
    reason_t          rsn;
    logic [PCT_W-1:0] target;

    if (it.clear_latch) begin
      latched = 1'b0;
      latched_code = RSN_SAFE;
    end

    ed = !it.elec_ok || it.volt_state == VOLT_HI_DANGER ||
         it.volt_state == VOLT_LO_DANGER || it.curr_state == CURR_DANGER;
    ew = !ed && (it.volt_state == VOLT_OVER_WARN || it.volt_state == VOLT_UNDER_WARN ||
                 it.curr_state == CURR_WARN);
    warns = int'(it.temp_grade == SENS_WARN) + int'(it.gas_state == SENS_WARN) + int'(ew);
    tdng = it.temp_grade >= SENS_DANGER;
    gdng = it.gas_state >= SENS_DANGER;
    dnow = 1'b0;

    // Only gas-alone danger waits out the debounce; the run counter saturates at the setting.
    if (tdng || gdng || ed) begin
      if (gas_run < limits.debounce) gas_run = gas_run + 1'b1;
      if (tdng || ed) begin
        dnow = 1'b1;
      end else if (gas_run >= limits.debounce) begin
        dnow = 1'b1;
      end else if (warns == 0) begin
        warns = 1;
      end
    end else begin
      gas_run = '0;
    end

    if (it.temp_grade == SENS_FAULT) rsn = RSN_TEMP_FAULT;
    else if (it.temp_grade == SENS_DANGER) rsn = RSN_TEMP_DANGER;
    else if (it.gas_state == SENS_FAULT) rsn = RSN_GAS_FAULT;
    else if (it.gas_state == SENS_DANGER) rsn = RSN_GAS_DANGER;
    else if (!it.elec_ok) rsn = RSN_ELEC_INVALID;
    else if (it.volt_state == VOLT_HI_DANGER) rsn = RSN_VOLT_OVER_D;
    else if (it.volt_state == VOLT_LO_DANGER) rsn = RSN_VOLT_UNDER_D;
    else if (it.curr_state == CURR_DANGER) rsn = RSN_CURR_DANGER;
    else if (it.temp_grade == SENS_WARN) rsn = RSN_TEMP_WARN;
    else if (it.gas_state == SENS_WARN) rsn = RSN_GAS_WARN;
    else if (it.volt_state == VOLT_OVER_WARN) rsn = RSN_VOLT_OVER_W;
    else if (it.volt_state == VOLT_UNDER_WARN) rsn = RSN_VOLT_UNDER_W;
    else if (it.curr_state == CURR_WARN) rsn = RSN_CURR_WARN;
    else rsn = RSN_SAFE;

    if (dnow && !latched) begin
      latched = 1'b1;
      latched_code = rsn;
    end

    if (dnow) target = '0;
    else if (warns == 0) target = limits.base_limit;
    else if (warns == 1) target = limits.one_warn;
    else if (warns == 2) target = limits.two_warn;
    else target = limits.three_warn;

    if (applied > target) begin
      step = dnow ? int'(limits.ramp_danger) : int'(limits.ramp_down);
      gap = int'(applied) - int'(target);
      applied = (gap > step) ? PCT_W'(int'(applied) - step) : target;
    end else if (applied < target) begin
      step = int'(limits.ramp_up);
      gap = int'(target) - int'(applied);
      applied = (gap > step) ? PCT_W'(int'(applied) + step) : target;
    end

    r.limited_pct    = (it.request_pct > {1'b0, applied}) ? {1'b0, applied} : it.request_pct;
    r.applied_pct    = applied;
    r.target_pct     = target;
    r.warn_count     = 2'(warns);
    r.danger_now     = dnow;
    r.danger_latched = latched;
    r.elec_warn      = ew;
    r.elec_danger    = ed;
    r.now_reason     = rsn;
    r.latched_reason = latched_code;
    if (dnow || warns > 0) r.banner_reason = rsn;
    else if (latched) r.banner_reason = latched_code;
    else r.banner_reason = RSN_SAFE;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      limits = '{BASE_LIMIT_RST, ONE_WARN_RST, TWO_WARN_RST, THREE_WARN_RST,
                 RAMP_DOWN_RST, RAMP_DANGER_RST, RAMP_UP_RST, DEBOUNCE_RST};
      gas_run = '0;
      latched = 1'b0;
      latched_code = RSN_SAFE;
      applied = BASE_LIMIT_RST;
      expected_limits.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          REG_BASE_LIMIT:  limits.base_limit = cfg_wdata;
          REG_ONE_WARN:    limits.one_warn = cfg_wdata;
          REG_TWO_WARN:    limits.two_warn = cfg_wdata;
          REG_THREE_WARN:  limits.three_warn = cfg_wdata;
          REG_RAMP_DOWN:   limits.ramp_down = cfg_wdata;
          REG_RAMP_DANGER: limits.ramp_danger = cfg_wdata;
          REG_RAMP_UP:     limits.ramp_up = cfg_wdata;
          REG_DEBOUNCE:    limits.debounce = cfg_wdata[RUN_W-1:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        seen = '{temp_grade: in_ch.temp_grade, gas_state: in_ch.gas_state,
                 volt_state: in_ch.volt_state, curr_state: in_ch.curr_state,
                 elec_ok: in_ch.elec_ok, clear_latch: in_ch.clear_latch,
                 request_pct: in_ch.request_pct};
        expected_limits.push_back(predict_period(seen));
      end

      if (out_ch.valid && out_ch.ready) begin
        if (expected_limits.size() == 0) begin
          $error("result transfer with no period outstanding");
          mismatches++;
        end else begin
          exp_r = expected_limits.pop_front();
          check_field("limited_pct", exp_r.limited_pct, out_ch.limited_pct);
          check_field("applied_pct", exp_r.applied_pct, out_ch.applied_pct);
          check_field("target_pct", exp_r.target_pct, out_ch.target_pct);
          check_field("warn_count", exp_r.warn_count, out_ch.warn_count);
          check_field("danger_now", exp_r.danger_now, out_ch.danger_now);
          check_field("danger_latched", exp_r.danger_latched, out_ch.danger_latched);
          check_field("elec_warn", exp_r.elec_warn, out_ch.elec_warn);
          check_field("elec_danger", exp_r.elec_danger, out_ch.elec_danger);
          check_field("now_reason", exp_r.now_reason, out_ch.now_reason);
          check_field("latched_reason", exp_r.latched_reason, out_ch.latched_reason);
          check_field("banner_reason", exp_r.banner_reason, out_ch.banner_reason);
        end
      end

      pending <= expected_limits.size();
    end
  end

endmodule

@@ verif/tb_battery_safety_limit_manager.sv @@
// Top testbench: clock, reset, register settings, period stimulus, pacing and verdict.
`timescale 1ns / 100ps

module tb_battery_safety_limit_manager;
  import bslm_pkg::*;

  localparam int PACE_FREE        = 0;
  localparam int PACE_SEND_GAPS   = 1;
  localparam int PACE_RECV_STALLS = 2;
  localparam int PACE_BOTH        = 3;
  localparam int NUM_PHASES       = 8;
  localparam int PHASE_ITEMS      = 92;

  localparam logic [2:0] VOLT_OK       = 3'd0;
  localparam logic [2:0] VOLT_UNDEF_LO = 3'd5;
  localparam logic [2:0] VOLT_UNDEF_HI = 3'd7;
  localparam logic [1:0] CURR_OK       = 2'd0;
  localparam logic [1:0] CURR_UNDEF    = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    pending;
  int                    send_idle_pct;
  int                    stall_pct;
  int                    periods_sent;
  int                    settings_used;
  int                    gas_burst_left;

  bslm_in_if  in_ch ();
  bslm_out_if out_ch ();

  battery_safety_limit_manager DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  bslm_limit_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic item_t period(logic [1:0] t, logic [1:0] g, logic [2:0] v, logic [1:0] c,
                                   logic ok, logic clr, logic [REQ_W-1:0] req);
    item_t it;
    it = '{temp_grade: t, gas_state: g, volt_state: v, curr_state: c,
           elec_ok: ok, clear_latch: clr, request_pct: req};
    return it;
  endfunction

  // Mostly gas-only danger bursts of random length so the debounce is crossed or just
  // missed; the rest is loosely weighted noise over every field value.
  function automatic item_t random_period();
    item_t it;
    it.request_pct = REQ_W'($urandom_range(255));
    it.clear_latch = ($urandom_range(9) == 0);
    it.elec_ok     = ($urandom_range(11) != 0);
    it.volt_state  = ($urandom_range(2) == 0) ? 3'($urandom_range(7)) : VOLT_OK;
    it.curr_state  = ($urandom_range(2) == 0) ? 2'($urandom_range(3)) : CURR_OK;
    if ($urandom_range(3) == 0) it.temp_grade = 2'($urandom_range(3));
    else it.temp_grade = ($urandom_range(2) == 0) ? SENS_WARN : SENS_NORMAL;

    if (gas_burst_left > 0) begin
      gas_burst_left--;
      if ($urandom_range(11) == 0) it.gas_state = SENS_WARN;
      else it.gas_state = ($urandom_range(1) != 0) ? SENS_FAULT : SENS_DANGER;
      if ($urandom_range(9) < 7) begin
        it.elec_ok = 1'b1;
        if (it.temp_grade >= SENS_DANGER) it.temp_grade = SENS_WARN;
        if (it.volt_state == VOLT_HI_DANGER || it.volt_state == VOLT_LO_DANGER)
          it.volt_state = VOLT_UNDEF_LO;
        if (it.curr_state == CURR_DANGER) it.curr_state = CURR_WARN;
      end
    end else begin
      if ($urandom_range(9) == 0) gas_burst_left = $urandom_range(1, 18);
      if ($urandom_range(4) == 0) it.gas_state = 2'($urandom_range(3));
      else it.gas_state = ($urandom_range(1) != 0) ? SENS_WARN : SENS_NORMAL;
    end
    return it;
  endfunction

  task automatic send_period(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.temp_grade  <= it.temp_grade;
    in_ch.gas_state   <= it.gas_state;
    in_ch.volt_state  <= it.volt_state;
    in_ch.curr_state  <= it.curr_state;
    in_ch.elec_ok     <= it.elec_ok;
    in_ch.clear_latch <= it.clear_latch;
    in_ch.request_pct <= it.request_pct;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    periods_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic load_limits(int setting);
    int v[8];
    case (setting)
      0: v = '{80, 60, 40, 0, 2, 3, 3, 2};
      1: v = '{100, 100, 100, 100, 100, 100, 100, 15};
      2: v = '{0, 0, 0, 0, 1, 1, 1, 1};
      // Zero up and down steps freeze the ramp outside danger, and a zero debounce makes gas danger immediate.
      3: v = '{127, 90, 127, 10, 0, 1, 0, 0};
      4: v = '{127, 127, 0, 127, 127, 127, 127, 15};
      default: begin
        foreach (v[i]) v[i] = (i < 4) ? $urandom_range(100) : $urandom_range(1, 20);
        v[7] = $urandom_range(15);
      end
    endcase
    write_reg(REG_BASE_LIMIT, v[0]);
    write_reg(REG_ONE_WARN, v[1]);
    write_reg(REG_TWO_WARN, v[2]);
    write_reg(REG_THREE_WARN, v[3]);
    write_reg(REG_RAMP_DOWN, v[4]);
    write_reg(REG_RAMP_DANGER, v[5]);
    write_reg(REG_RAMP_UP, v[6]);
    write_reg(REG_DEBOUNCE, v[7]);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  initial begin
    item_t directed[$];

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_BASE_LIMIT;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.temp_grade  = SENS_NORMAL;
    in_ch.gas_state   = SENS_NORMAL;
    in_ch.volt_state  = VOLT_OK;
    in_ch.curr_state  = CURR_OK;
    in_ch.elec_ok     = 1'b1;
    in_ch.clear_latch = 1'b0;
    in_ch.request_pct = '0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    periods_sent      = 0;
    settings_used     = 0;
    gas_burst_left    = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_limits(0);
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_OK, CURR_OK, 1'b1, 1'b0, 8'd255));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_OK, CURR_OK, 1'b1, 1'b0, 8'd0));
    directed.push_back(period(SENS_WARN, SENS_NORMAL, VOLT_OK, CURR_OK, 1'b1, 1'b0, 8'd128));
    directed.push_back(period(SENS_NORMAL, SENS_WARN, VOLT_OK, CURR_OK, 1'b1, 1'b0, 8'd70));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_OVER_WARN, CURR_OK,
                              1'b1, 1'b0, 8'd90));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_UNDER_WARN, CURR_OK,
                              1'b1, 1'b0, 8'd90));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_OK, CURR_WARN, 1'b1, 1'b0, 8'd90));
    directed.push_back(period(SENS_WARN, SENS_WARN, VOLT_OVER_WARN, CURR_OK,
                              1'b1, 1'b0, 8'd127));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_UNDEF_LO, CURR_UNDEF,
                              1'b1, 1'b0, 8'd100));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_UNDEF_HI, CURR_OK,
                              1'b1, 1'b0, 8'd200));
    // Gas danger pending, then declared, then held as a fault.
    directed.push_back(period(SENS_NORMAL, SENS_DANGER, VOLT_OK, CURR_OK, 1'b1, 1'b0, 8'd255));
    directed.push_back(period(SENS_NORMAL, SENS_DANGER, VOLT_OK, CURR_OK, 1'b1, 1'b0, 8'd255));
    directed.push_back(period(SENS_NORMAL, SENS_FAULT, VOLT_OK, CURR_OK, 1'b1, 1'b0, 8'd255));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_OK, CURR_OK, 1'b1, 1'b0, 8'd255));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_OK, CURR_OK, 1'b1, 1'b1, 8'd255));
    directed.push_back(period(SENS_NORMAL, SENS_FAULT, VOLT_OK, CURR_OK, 1'b1, 1'b0, 8'd50));
    // Clear together with danger relatches in the same period.
    directed.push_back(period(SENS_FAULT, SENS_NORMAL, VOLT_OK, CURR_OK, 1'b1, 1'b1, 8'd50));
    directed.push_back(period(SENS_DANGER, SENS_NORMAL, VOLT_OK, CURR_OK, 1'b1, 1'b0, 8'd50));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_OVER_WARN, CURR_WARN,
                              1'b0, 1'b1, 8'd50));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_HI_DANGER, CURR_OK,
                              1'b1, 1'b1, 8'd50));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_LO_DANGER, CURR_OK,
                              1'b1, 1'b1, 8'd50));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_OK, CURR_DANGER,
                              1'b1, 1'b1, 8'd50));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_OK, CURR_OK, 1'b1, 1'b1, 8'd255));
    directed.push_back(period(SENS_WARN, SENS_DANGER, VOLT_OK, CURR_WARN, 1'b1, 1'b0, 8'd30));
    directed.push_back(period(SENS_NORMAL, SENS_NORMAL, VOLT_OK, CURR_OK, 1'b1, 1'b0, 8'd255));
    foreach (directed[i]) send_period(directed[i]);
    wait_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      load_limits(phase);
      case (phase % 4)
        PACE_FREE:        begin send_idle_pct = 0;  stall_pct = 0;  end
        PACE_SEND_GAPS:   begin send_idle_pct = 73; stall_pct = 0;  end
        PACE_RECV_STALLS: begin send_idle_pct = 0;  stall_pct = 73; end
        PACE_BOTH:        begin send_idle_pct = 30; stall_pct = 30; end
        default: ;
      endcase
      repeat (PHASE_ITEMS) send_period(random_period());
      wait_drained();
    end

    $display("Checked %0d evaluation periods under %0d register settings,", periods_sent,
             settings_used);
    $display("with free running, sender gaps, receiver stalls and mixed pacing.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bslm_pkg.sv
rtl/bslm_in_if.sv
rtl/bslm_out_if.sv
rtl/bslm_cfg_regs.sv
rtl/bslm_eval.sv
rtl/battery_safety_limit_manager.sv
verif/bslm_limit_check.sv
verif/tb_battery_safety_limit_manager.sv
